FILE: hw/rtl/ppq_pkg.sv
// shared types, constants and codes for the polynomial prefix hash query unit
`timescale 1ns / 1ps

package ppq_pkg;

    // field widths
    localparam int HASH_W   = 30;
    localparam int POS_W    = 10;
    localparam int LETTER_W = 5;
    localparam int CODE_W   = 2;

    // modulus and barrett reciprocal floor(2^60 / p)
    localparam logic [HASH_W-1:0] HASH_PRIME = 30'd1000000007;
    localparam logic [30:0]       BARRETT_MU = 31'((64'd1 << 60) / 64'(HASH_PRIME));

    localparam logic [HASH_W-1:0] HASH_BASE_RST = 30'd31;

    localparam int DEF_MAX_LEN = 1024;
    localparam int Q_DEPTH     = 2;

    // opcodes
    localparam logic [CODE_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [CODE_W-1:0] OP_APPEND = 2'd1;
    localparam logic [CODE_W-1:0] OP_QUERY  = 2'd2;

    // status codes
    localparam logic [CODE_W-1:0] ST_OK    = 2'd0;
    localparam logic [CODE_W-1:0] ST_RANGE = 2'd1;
    localparam logic [CODE_W-1:0] ST_FULL  = 2'd2;

    // work classes handed from front to back
    typedef enum logic [1:0] {
        K_ZERO,
        K_APPEND,
        K_QUERY
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [CODE_W-1:0]    status;
        logic                 first;
        logic [LETTER_W-1:0]  letter;
    } t_ctl;

    // back-end sequencer states
    typedef enum logic [2:0] {
        BS_IDLE,
        BS_READ,
        BS_READ2,
        BS_MUL1,
        BS_MUL2,
        BS_WAIT,
        BS_FIN,
        BS_OUT
    } t_bstate;

endpackage

FILE: hw/rtl/ppq_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module ppq_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/ppq_queue.sv
// small register fifo between the front classifier and the back sequencer
`timescale 1ns / 1ps

module ppq_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_ent [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_ent[r_rd_ptr];

endmodule

FILE: hw/rtl/ppq_front.sv
// front end: tracks string length, classifies each item and builds its command
`timescale 1ns / 1ps

module ppq_front #(
    parameter int MAX_LEN = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_q_full,
    input  logic [ppq_pkg::CODE_W-1:0]   i_opcode,
    input  logic [ppq_pkg::LETTER_W-1:0] i_letter,
    input  logic [ppq_pkg::POS_W-1:0]    i_left,
    input  logic [ppq_pkg::POS_W-1:0]    i_right,
    output logic                         o_ready,
    output logic                         o_push,
    output ppq_pkg::t_ctl                o_ctl,
    output logic [$clog2(MAX_LEN)-1:0]   o_addr_a,
    output logic [$clog2(MAX_LEN)-1:0]   o_addr_b,
    output logic [$clog2(MAX_LEN)-1:0]   o_addr_p
);

    import ppq_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = (LW > POS_W) ? LW : POS_W;

    logic [LW-1:0]    r_len, n_len;
    logic [POS_W-1:0] w_span;
    logic [POS_W-1:0] w_left_m1;

    assign o_ready   = !i_q_full;
    assign o_push    = i_valid && !i_q_full;
    assign w_span    = i_right - i_left + POS_W'(1);
    assign w_left_m1 = i_left - POS_W'(1);

    always_comb begin
        n_len        = r_len;
        o_ctl.kind   = K_ZERO;
        o_ctl.status = ST_OK;
        o_ctl.first  = 1'b0;
        o_ctl.letter = i_letter;
        o_addr_a     = AW'(i_right);
        o_addr_b     = AW'(w_left_m1);
        o_addr_p     = AW'(w_span);
        unique case (i_opcode)
            OP_CLEAR: begin
                n_len = '0;
            end
            OP_APPEND: begin
                if (r_len == LW'(MAX_LEN)) begin
                    o_ctl.status = ST_FULL;
                end else begin
                    // addr_b carries the write slot on append
                    o_ctl.kind  = K_APPEND;
                    o_ctl.first = (r_len == '0);
                    o_addr_a    = AW'(r_len - LW'(1));
                    o_addr_p    = AW'(r_len - LW'(1));
                    o_addr_b    = AW'(r_len);
                    n_len       = r_len + LW'(1);
                end
            end
            OP_QUERY: begin
                if ((i_left > i_right) || (CW'(i_right) >= CW'(r_len))) begin
                    o_ctl.status = ST_RANGE;
                end else begin
                    o_ctl.kind  = K_QUERY;
                    o_ctl.first = (i_left == '0);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (o_push) begin
            r_len <= n_len;
        end
    end

endmodule

FILE: hw/rtl/ppq_mulmod.sv
// pipelined 30x30 multiply reduced mod p by barrett
`timescale 1ns / 1ps

module ppq_mulmod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [ppq_pkg::HASH_W-1:0] i_a,
    input  logic [ppq_pkg::HASH_W-1:0] i_b,
    output logic                       o_valid,
    output logic [ppq_pkg::HASH_W-1:0] o_res
);

    import ppq_pkg::*;

    localparam logic [31:0] P1 = 32'(HASH_PRIME);
    localparam logic [31:0] P2 = P1 << 1;

    logic        r_v1, r_v2, r_v3, r_v4;
    logic [59:0] w_x;
    logic [59:0] r_x;
    logic [61:0] w_t;
    logic [61:0] r_t;
    logic [31:0] r_xlo2, r_xlo3;
    logic [30:0] w_q;
    logic [60:0] w_qp;
    logic [31:0] r_qp;
    logic [31:0] w_r;
    logic [HASH_W-1:0] r_res;

    assign w_x  = i_a * i_b;
    assign w_t  = r_x[59:29] * BARRETT_MU;
    assign w_q  = r_t[61:31];
    assign w_qp = w_q * HASH_PRIME;
    // remainder estimate stays below 3p
    assign w_r  = r_xlo3 - r_qp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= w_x;
        r_t    <= w_t;
        r_xlo2 <= r_x[31:0];
        r_xlo3 <= r_xlo2;
        r_qp   <= w_qp[31:0];
        if (w_r >= P2) begin
            r_res <= HASH_W'(w_r - P2);
        end else if (w_r >= P1) begin
            r_res <= HASH_W'(w_r - P1);
        end else begin
            r_res <= HASH_W'(w_r);
        end
    end

    assign o_valid = r_v4;
    assign o_res   = r_res;

endmodule

FILE: hw/rtl/ppq_back.sv
// back end: sequences table reads, modular multiplies, table writes and the result register
`timescale 1ns / 1ps

module ppq_back #(
    parameter int MAX_LEN = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [ppq_pkg::HASH_W-1:0]  i_cfg_data,
    input  logic                        i_q_valid,
    output logic                        o_q_pop,
    input  ppq_pkg::t_ctl               i_ctl,
    input  logic [$clog2(MAX_LEN)-1:0]  i_addr_a,
    input  logic [$clog2(MAX_LEN)-1:0]  i_addr_b,
    input  logic [$clog2(MAX_LEN)-1:0]  i_addr_p,
    output logic                        o_m_valid,
    input  logic                        i_m_ready,
    output logic [ppq_pkg::HASH_W-1:0]  o_m_hash,
    output logic [ppq_pkg::CODE_W-1:0]  o_m_status
);

    import ppq_pkg::*;

    localparam int AW = $clog2(MAX_LEN);

    t_bstate           r_state, n_state;
    t_ctl              r_cmd;
    logic [AW-1:0]     r_addr_a, r_addr_b, r_addr_p;
    logic [HASH_W-1:0] r_hash_base;
    logic [HASH_W-1:0] r_op_a, r_op_p;
    logic [HASH_W-1:0] r_m1, r_m2;
    logic              r_got1;
    logic [HASH_W-1:0] r_res_hv;
    logic [CODE_W-1:0] r_res_st;
    logic              r_out_valid;
    logic [HASH_W-1:0] r_out_hv;
    logic [CODE_W-1:0] r_out_st;

    logic              w_p_re, w_w_re, w_we;
    logic [AW-1:0]     w_p_raddr;
    logic [HASH_W-1:0] w_p_rdata, w_w_rdata;
    logic [HASH_W-1:0] w_w_wdata;
    logic              w_mul_in_valid, w_mul_valid;
    logic [HASH_W-1:0] w_mul_a, w_mul_b, w_mul_res;
    logic              w_out_free;
    logic [HASH_W:0]   w_sum, w_add, w_sub;
    logic [HASH_W-1:0] w_fin_hv;

    assign w_out_free = !r_out_valid || i_m_ready;

    ppq_ram #(.WIDTH(HASH_W), .DEPTH(MAX_LEN)) u_prefix_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_addr_b),
        .i_wdata (w_fin_hv),
        .i_re    (w_p_re),
        .i_raddr (w_p_raddr),
        .o_rdata (w_p_rdata)
    );

    ppq_ram #(.WIDTH(HASH_W), .DEPTH(MAX_LEN)) u_power_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_addr_b),
        .i_wdata (w_w_wdata),
        .i_re    (w_w_re),
        .i_raddr (r_addr_p),
        .o_rdata (w_w_rdata)
    );

    ppq_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mul_in_valid),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_valid (w_mul_valid),
        .o_res   (w_mul_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    if (i_ctl.kind == K_ZERO || (i_ctl.kind == K_APPEND && i_ctl.first)) begin
                        n_state = BS_FIN;
                    end else begin
                        n_state = BS_READ;
                    end
                end
            end
            BS_READ:  n_state = BS_READ2;
            BS_READ2: begin
                n_state = (r_cmd.kind == K_QUERY && r_cmd.first) ? BS_FIN : BS_MUL1;
            end
            BS_MUL1:  n_state = (r_cmd.kind == K_APPEND) ? BS_MUL2 : BS_WAIT;
            BS_MUL2:  n_state = BS_WAIT;
            BS_WAIT: begin
                if (w_mul_valid && (r_cmd.kind == K_QUERY || r_got1)) begin
                    n_state = BS_FIN;
                end
            end
            BS_FIN:   n_state = BS_OUT;
            BS_OUT: begin
                if (w_out_free) begin
                    n_state = BS_IDLE;
                end
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_q_pop        = 1'b0;
        w_p_re         = 1'b0;
        w_p_raddr      = r_addr_a;
        w_w_re         = 1'b0;
        w_we           = 1'b0;
        w_mul_in_valid = 1'b0;
        w_mul_a        = r_op_a;
        w_mul_b        = r_hash_base;
        unique case (r_state)
            BS_IDLE:  o_q_pop = i_q_valid;
            BS_READ: begin
                w_p_re = 1'b1;
                w_w_re = 1'b1;
            end
            BS_READ2: begin
                w_p_re    = (r_cmd.kind == K_QUERY);
                w_p_raddr = r_addr_b;
            end
            BS_MUL1: begin
                w_mul_in_valid = 1'b1;
                if (r_cmd.kind == K_QUERY) begin
                    w_mul_a = w_p_rdata;
                    w_mul_b = r_op_p;
                end
            end
            BS_MUL2: begin
                w_mul_in_valid = 1'b1;
                w_mul_a        = r_op_p;
            end
            BS_WAIT: begin
            end
            BS_FIN:   w_we = (r_cmd.kind == K_APPEND);
            BS_OUT: begin
            end
        endcase
    end

    // final add or subtract mod p
    always_comb begin
        w_sum = {1'b0, r_m1} + (HASH_W + 1)'(r_cmd.letter) + (HASH_W + 1)'(1);
        w_add = (w_sum >= {1'b0, HASH_PRIME}) ? w_sum - {1'b0, HASH_PRIME} : w_sum;
        if (r_op_a >= r_m1) begin
            w_sub = {1'b0, r_op_a} - {1'b0, r_m1};
        end else begin
            w_sub = {1'b0, r_op_a} + {1'b0, HASH_PRIME} - {1'b0, r_m1};
        end
        case (r_cmd.kind)
            K_APPEND: begin
                w_fin_hv = r_cmd.first ? HASH_W'(r_cmd.letter) + HASH_W'(1)
                                       : w_add[HASH_W-1:0];
            end
            K_QUERY:  w_fin_hv = r_cmd.first ? r_op_a : w_sub[HASH_W-1:0];
            default:  w_fin_hv = '0;
        endcase
        w_w_wdata = r_cmd.first ? HASH_W'(1) : r_m2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_hash_base <= HASH_BASE_RST;
            r_got1      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_hash_base <= i_cfg_data;
            end
            if (r_state == BS_MUL1) begin
                r_got1 <= 1'b0;
            end else if (r_state == BS_WAIT && w_mul_valid) begin
                r_got1 <= 1'b1;
            end
            if (r_state == BS_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd    <= i_ctl;
            r_addr_a <= i_addr_a;
            r_addr_b <= i_addr_b;
            r_addr_p <= i_addr_p;
        end
        if (r_state == BS_READ2) begin
            r_op_a <= w_p_rdata;
            r_op_p <= w_w_rdata;
        end
        if (r_state == BS_WAIT && w_mul_valid) begin
            if (!r_got1) begin
                r_m1 <= w_mul_res;
            end else begin
                r_m2 <= w_mul_res;
            end
        end
        if (r_state == BS_FIN) begin
            r_res_hv <= w_fin_hv;
            r_res_st <= r_cmd.status;
        end
        if (r_state == BS_OUT && w_out_free) begin
            r_out_hv <= r_res_hv;
            r_out_st <= r_res_st;
        end
    end

    assign o_m_valid  = r_out_valid;
    assign o_m_hash   = r_out_hv;
    assign o_m_status = r_out_st;

`ifndef NO_ASSERTIONS
    a_mul_only_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_valid |-> (r_state == BS_WAIT))
        else $error("multiply result arrived outside the wait state");

    a_query_mul_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_MUL1 && r_cmd.kind == K_QUERY) |=> ##3 w_mul_valid)
        else $error("query multiply result did not arrive after four cycles");

    a_error_hash_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_st != ST_OK) |-> (r_out_hv == '0))
        else $error("error result carries a nonzero hash");
`endif

endmodule

FILE: hw/rtl/polynomial_prefix_hash_query_unit.sv
// top level of the polynomial prefix hash query unit
`timescale 1ns / 1ps

// usage:
// - slave stream takes one command per transfer: tuser holds the opcode (clear, append
//   letter, query substring), tdata the letter and the query positions
// - master stream returns exactly one result per command, in order: tdata holds the
//   hash, tuser the status (ok, query range invalid, store full)
// - cfg channel writes the hash base; it is always ready and must only be written
//   while no command is in flight
// - a front end classifies each command against its own length count and pushes it
//   into a two-entry queue, so the slave side keeps taking commands while the back
//   end works and while a result waits on the master side
// - the back end sequencer runs one command at a time through the table reads and a
//   four-stage barrett multiply pipeline; an append reads both tables and runs two
//   multiplies, a query with a nonzero left position reads both tables and runs one,
//   a query at position zero only reads the tables, and clear, errors and the first
//   append go straight to the final step
// - reset clears the length count, the queue, the sequencer and the output valid, and
//   sets the base to 31; the tables need no clearing pass
// - when the master side stalls, the result holds in the output register, the back
//   end waits with the next result, and the queue fills until tready drops

module polynomial_prefix_hash_query_unit #(
    parameter int MAX_LEN = ppq_pkg::DEF_MAX_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel: hash base
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [29:0] i_cfg_data,
    // command stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [4:0] letter, [14:5] left_pos, [24:15] right_pos
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] opcode
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // [29:0] hash_value
    output logic [1:0]  o_m_axis_tuser   // [1:0] status
);

    import ppq_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int QW = $bits(t_ctl) + 3 * AW;

    logic          w_q_full, w_q_valid, w_push, w_pop;
    t_ctl          w_f_ctl, w_b_ctl;
    logic [AW-1:0] w_f_addr_a, w_f_addr_b, w_f_addr_p;
    logic [AW-1:0] w_b_addr_a, w_b_addr_b, w_b_addr_p;
    logic [QW-1:0] w_q_din, w_q_dout;
    logic [HASH_W-1:0] w_hash;

    // config port never stalls
    assign o_cfg_ready = 1'b1;

    ppq_front #(.MAX_LEN(MAX_LEN)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_q_full (w_q_full),
        .i_opcode (i_s_axis_tuser[1:0]),
        .i_letter (i_s_axis_tdata[4:0]),
        .i_left   (i_s_axis_tdata[14:5]),
        .i_right  (i_s_axis_tdata[24:15]),
        .o_ready  (o_s_axis_tready),
        .o_push   (w_push),
        .o_ctl    (w_f_ctl),
        .o_addr_a (w_f_addr_a),
        .o_addr_b (w_f_addr_b),
        .o_addr_p (w_f_addr_p)
    );

    // command queue entry: control word then the three table addresses
    assign w_q_din = {w_f_ctl, w_f_addr_a, w_f_addr_b, w_f_addr_p};
    assign {w_b_ctl, w_b_addr_a, w_b_addr_b, w_b_addr_p} = w_q_dout;

    ppq_queue #(.WIDTH(QW), .DEPTH(Q_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_din),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_dout)
    );

    ppq_back #(.MAX_LEN(MAX_LEN)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (w_q_valid),
        .o_q_pop     (w_pop),
        .i_ctl       (w_b_ctl),
        .i_addr_a    (w_b_addr_a),
        .i_addr_b    (w_b_addr_b),
        .i_addr_p    (w_b_addr_p),
        .o_m_valid   (o_m_axis_tvalid),
        .i_m_ready   (i_m_axis_tready),
        .o_m_hash    (w_hash),
        .o_m_status  (o_m_axis_tuser)
    );

    // hash padded to a whole word
    assign o_m_axis_tdata = {2'b00, w_hash};

endmodule

FILE: verif/polynomial_prefix_hash_query_unit_tb.sv
// self-checking testbench for the polynomial prefix hash query unit
`timescale 1ns / 1ps

module polynomial_prefix_hash_query_unit_tb;

    import ppq_pkg::*;

    localparam int MAX_LEN = DEF_MAX_LEN;
    // fourth opcode value, not named in the package; the block treats it as a no-op
    localparam logic [CODE_W-1:0] OP_UNUSED = 2'd3;
    // cycles to let pass once the last reply has come, before touching the base
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT = 20000;

    typedef struct {
        logic [HASH_W-1:0] hash;
        logic [CODE_W-1:0] status;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [29:0] i_cfg_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;  // [4:0] letter, [14:5] left_pos, [24:15] right_pos
    logic [1:0]  i_s_axis_tuser = '0;  // [1:0] opcode
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;       // [29:0] hash_value
    logic [1:0]  o_m_axis_tuser;       // [1:0] status

    polynomial_prefix_hash_query_unit #(
        .MAX_LEN(MAX_LEN)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predicted copy of the block state
    logic [HASH_W-1:0] prefix_tab [0:MAX_LEN-1];
    logic [HASH_W-1:0] power_tab  [0:MAX_LEN-1];
    int                str_len = 0;
    logic [HASH_W-1:0] cur_base = HASH_BASE_RST;

    t_reply pending_replies [$];
    int     fail_count = 0;

    // idling control for both sides
    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    int rx_hold_req = 0;

    function automatic logic [HASH_W-1:0] mulmod(input logic [HASH_W-1:0] a,
                                                 input logic [HASH_W-1:0] b);
        logic [63:0] prod;
        prod = {34'd0, a} * {34'd0, b};
        return HASH_W'(prod % {34'd0, HASH_PRIME});
    endfunction

    // applies one command to the predicted state and returns the reply it yields
    function automatic t_reply predict_reply(input logic [CODE_W-1:0] op,
                                             input logic [LETTER_W-1:0] ltr,
                                             input logic [POS_W-1:0] lp,
                                             input logic [POS_W-1:0] rp);
        t_reply            r;
        logic [HASH_W-1:0] prev_h;
        logic [HASH_W-1:0] pw;
        logic [HASH_W-1:0] sub;
        logic [HASH_W:0]   sum;
        r.hash = '0;
        r.status = ST_OK;
        case (op)
            OP_CLEAR: begin
                str_len = 0;
            end
            OP_APPEND: begin
                if (str_len >= MAX_LEN) begin
                    r.status = ST_FULL;
                end else begin
                    prev_h = '0;
                    pw = HASH_W'(1);
                    if (str_len > 0) begin
                        prev_h = prefix_tab[str_len-1];
                        pw = mulmod(power_tab[str_len-1], cur_base);
                    end
                    sum = {1'b0, mulmod(prev_h, cur_base)} + (HASH_W+1)'(ltr)
                          + (HASH_W+1)'(1);
                    if (sum >= {1'b0, HASH_PRIME}) sum = sum - {1'b0, HASH_PRIME};
                    r.hash = sum[HASH_W-1:0];
                    prefix_tab[str_len] = r.hash;
                    power_tab[str_len] = pw;
                    str_len++;
                end
            end
            OP_QUERY: begin
                if (lp > rp || int'(rp) >= str_len) begin
                    r.status = ST_RANGE;
                end else begin
                    r.hash = prefix_tab[rp];
                    if (lp > 0) begin
                        sub = mulmod(prefix_tab[int'(lp)-1], power_tab[int'(rp)-int'(lp)+1]);
                        r.hash = (r.hash >= sub) ? r.hash - sub : r.hash + HASH_PRIME - sub;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // offers one command, waits for its transfer and records the predicted reply;
    // entered and left at a falling edge, tvalid stays high for a following command
    task automatic send_cmd(input logic [CODE_W-1:0] op, input logic [LETTER_W-1:0] ltr,
                            input logic [POS_W-1:0] lp, input logic [POS_W-1:0] rp);
        while (tx_gaps && $urandom_range(99) < 33) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= op;
        i_s_axis_tdata <= {7'd0, rp, lp, ltr};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_replies.push_back(predict_reply(op, ltr, lp, rp));
        @(negedge i_clk);
    endtask

    task automatic wait_replies_drained();
        int waited;
        waited = 0;
        i_s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (pending_replies.size() != 0) begin
            $display("%0t: %0d replies still missing after drain wait",
                     $time, pending_replies.size());
            fail_count++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // base is only written with nothing in flight
    task automatic write_base(input logic [29:0] value);
        wait_replies_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_base = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_valid_query();
        logic [POS_W-1:0] rp;
        logic [POS_W-1:0] lp;
        rp = POS_W'($urandom_range(str_len - 1));
        lp = POS_W'($urandom_range(int'(rp)));
        send_cmd(OP_QUERY, LETTER_W'($urandom), lp, rp);
    endtask

    // extremes of the fields, every opcode, out-of-range letters and bad ranges
    task automatic test_directed_basics();
        send_cmd(OP_QUERY, 5'd0, 10'd0, 10'd0);
        send_cmd(OP_UNUSED, 5'd31, 10'd1023, 10'd1023);
        send_cmd(OP_APPEND, 5'd0, 10'd0, 10'd0);
        send_cmd(OP_APPEND, 5'd25, 10'd1023, 10'd1023);
        send_cmd(OP_APPEND, 5'd26, 10'd0, 10'd0);
        send_cmd(OP_APPEND, 5'd31, 10'd0, 10'd0);
        send_cmd(OP_QUERY, 5'd0, 10'd0, 10'd0);
        send_cmd(OP_QUERY, 5'd0, 10'd0, 10'd3);
        send_cmd(OP_QUERY, 5'd31, 10'd1, 10'd3);
        send_cmd(OP_QUERY, 5'd0, 10'd3, 10'd3);
        send_cmd(OP_QUERY, 5'd0, 10'd2, 10'd1);
        send_cmd(OP_QUERY, 5'd0, 10'd0, 10'd4);
        send_cmd(OP_QUERY, 5'd0, 10'd1023, 10'd1023);
        send_cmd(OP_QUERY, 5'd0, 10'd0, 10'd1023);
        send_cmd(OP_QUERY, 5'd0, 10'd1023, 10'd0);
        send_cmd(OP_CLEAR, 5'd31, 10'd1023, 10'd1023);
        send_cmd(OP_QUERY, 5'd0, 10'd0, 10'd0);
        send_cmd(OP_APPEND, 5'd12, 10'd0, 10'd0);
        send_cmd(OP_QUERY, 5'd0, 10'd0, 10'd0);
    endtask

    // extreme and out-of-range bases, and a base change in the middle of a string
    task automatic test_base_settings();
        logic [29:0] bases [6];
        bases = '{30'd2, 30'd1000000006, 30'd0, 30'd1, 30'd1000000007, 30'h3FFF_FFFF};
        foreach (bases[k]) begin
            write_base(bases[k]);
            send_cmd(OP_CLEAR, 5'd0, 10'd0, 10'd0);
            repeat (6) send_cmd(OP_APPEND, LETTER_W'($urandom_range(25)), 10'd0, 10'd0);
            repeat (3) send_valid_query();
            write_base(bases[(k + 1) % 6]);
            repeat (4) send_cmd(OP_APPEND, LETTER_W'($urandom_range(25)), 10'd0, 10'd0);
            send_cmd(OP_QUERY, 5'd0, 10'd2, 10'd8);
            send_cmd(OP_QUERY, 5'd0, 10'd0, 10'd9);
        end
        write_base(HASH_BASE_RST);
    endtask

    // fill the store to the top, with queries along the way, then push past it
    task automatic test_store_full();
        send_cmd(OP_CLEAR, 5'd0, 10'd0, 10'd0);
        for (int i = 0; i < MAX_LEN; i++) begin
            send_cmd(OP_APPEND, LETTER_W'($urandom_range(31)), POS_W'($urandom),
                     POS_W'($urandom));
            if (i % 64 == 63) send_valid_query();
        end
        send_cmd(OP_APPEND, 5'd3, 10'd0, 10'd0);
        send_cmd(OP_APPEND, 5'd31, 10'd1023, 10'd1023);
        send_cmd(OP_QUERY, 5'd0, 10'd0, 10'd1023);
        send_cmd(OP_QUERY, 5'd0, 10'd1023, 10'd1023);
        send_cmd(OP_QUERY, 5'd0, 10'd1, 10'd1023);
        send_cmd(OP_QUERY, 5'd0, 10'd512, 10'd1023);
        send_cmd(OP_QUERY, 5'd0, 10'd1023, 10'd1022);
        repeat (8) send_valid_query();
        send_cmd(OP_CLEAR, 5'd0, 10'd0, 10'd0);
        send_cmd(OP_QUERY, 5'd0, 10'd0, 10'd0);
        send_cmd(OP_APPEND, 5'd7, 10'd0, 10'd0);
    endtask

    // mostly appends and in-range queries, with clears, bad ranges and no-ops mixed in
    task automatic test_random_traffic(input int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                send_cmd(OP_APPEND,
                         ($urandom_range(9) == 0) ? LETTER_W'($urandom_range(31, 26))
                                                  : LETTER_W'($urandom_range(25)),
                         POS_W'($urandom), POS_W'($urandom));
            end else if (r < 82 && str_len > 0) begin
                send_valid_query();
            end else if (r < 90) begin
                send_cmd(OP_QUERY, LETTER_W'($urandom), POS_W'($urandom),
                         POS_W'($urandom_range(str_len + 2)));
            end else if (r < 94) begin
                send_cmd(OP_UNUSED, LETTER_W'($urandom), POS_W'($urandom), POS_W'($urandom));
            end else if (r < 97) begin
                send_cmd(OP_CLEAR, LETTER_W'($urandom), POS_W'($urandom), POS_W'($urandom));
            end else begin
                send_cmd(OP_QUERY, LETTER_W'($urandom), POS_W'($urandom), POS_W'($urandom));
            end
        end
    endtask

    // result side stalls for a long stretch while commands keep coming
    task automatic test_backpressure();
        tx_gaps = 1'b0;
        rx_hold_req = 300;
        repeat (40) begin
            if (str_len > 0 && $urandom_range(1) == 0) send_valid_query();
            else send_cmd(OP_APPEND, LETTER_W'($urandom_range(25)), 10'd0, 10'd0);
        end
        tx_gaps = 1'b1;
    endtask

    // receiver: random stalls, or a counted hold-off when one is requested
    initial begin : result_sink
        int hold;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                hold = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold > 0) begin
                hold--;
                i_m_axis_tready <= 1'b0;
            end else if (rx_gaps && $urandom_range(99) < 33) begin
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // each result transfer against the oldest predicted reply
    always @(posedge i_clk) begin : reply_check
        t_reply want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected reply, actual hash %0d status %0d",
                         $time, o_m_axis_tdata[29:0], o_m_axis_tuser);
                fail_count++;
            end else begin
                want = pending_replies.pop_front();
                if (o_m_axis_tdata[29:0] !== want.hash) begin
                    $display("%0t: hash_value mismatch, expected %0d, actual %0d",
                             $time, want.hash, o_m_axis_tdata[29:0]);
                    fail_count++;
                end
                if (o_m_axis_tuser !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, o_m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_basics();
        test_base_settings();
        test_store_full();
        test_backpressure();

        for (int ph = 0; ph < 5; ph++) begin
            if (ph == 3) write_base(30'($urandom));
            else write_base(30'($urandom_range(1000000006, 2)));
            // one long phase with both sides running flat out
            tx_gaps = (ph != 2);
            rx_gaps = (ph != 2);
            test_random_traffic((ph == 2) ? 60 : 12);
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;

        wait_replies_drained();
        if (pending_replies.size() != 0) fail_count++;
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/ppq_pkg.sv
hw/rtl/ppq_ram.sv
hw/rtl/ppq_queue.sv
hw/rtl/ppq_front.sv
hw/rtl/ppq_mulmod.sv
hw/rtl/ppq_back.sv
hw/rtl/polynomial_prefix_hash_query_unit.sv
verif/polynomial_prefix_hash_query_unit_tb.sv
